// ===== design/rscpm_pkg.sv =====
`default_nettype none

package rscpm_pkg;

    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int STRIDE_W = 14;
    localparam int OFFS_W   = 26;
    localparam int TGT_W    = 25;
    localparam int REL_W    = 27;
    localparam int QUO_W    = 12;
    localparam int REM_W    = TGT_W + DIM_W;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 14;
    localparam int CNT_W    = 5;

    localparam logic [DIM_W-1:0] MAX_DIM         = DIM_W'(4096);
    localparam logic [1:0]       BYTES_PER_PIXEL = 2'd3;

    localparam logic [CIDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ROW_STRIDE    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
    localparam logic [CIDX_W-1:0] REG_ROTATION      = 3'd5;
    localparam logic [CIDX_W-1:0] REG_SCALE_MODE    = 3'd6;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] MODE_FIT  = 2'd0;
    localparam logic [1:0] MODE_FILL = 2'd1;
    localparam logic [1:0] MODE_ORIG = 2'd2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] at_least_one(input logic [TGT_W-1:0] v);
        return (v == '0) ? TGT_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== design/rotate_scale_center_pixel_mapper.sv =====
// Channel   Direction  Signals
// s_        in         s_valid, s_ready, s_screen_x, s_screen_y
// m_        out        m_valid, m_ready, m_covered, m_source_x, m_source_y, m_source_offset
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One request enters per cycle unless setup is running or the output stalls; results leave in order.
// Target size and start are recomputed by a shared bit-serial divider after reset
// and after every configuration write; s_ready is low while this runs. The two per-pixel
// divisions use a 12-stage restoring pipeline.
// A stall holds only the stages that are full, so bubbles close up.
`default_nettype none

module rotate_scale_center_pixel_mapper
    import rscpm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_W-1:0]    s_screen_x,
    input  wire logic [COORD_W-1:0]    s_screen_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_covered,
    output logic [COORD_W-1:0]         m_source_x,
    output logic [COORD_W-1:0]         m_source_y,
    output logic [OFFS_W-1:0]          m_source_offset,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CIDX_W-1:0]     cfg_index,
    input  wire logic [CDATA_W-1:0]    cfg_data
);

    localparam int NST = QUO_W + 5;

    typedef enum logic [2:0] {
        SU_LOAD, SU_MUL1, SU_DIV1, SU_CHK, SU_DIV2, SU_START, SU_IDLE
    } setup_t;

    logic [DIM_W-1:0]    src_w_cfg_reg, src_h_cfg_reg, scr_w_cfg_reg, scr_h_cfg_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [1:0]          rot_reg, mode_reg;

    logic [DIM_W-1:0] w_reg, h_reg, xres_reg, yres_reg, rw_reg, rh_reg;
    logic [TGT_W-1:0] tw_reg, th_reg;
    logic signed [REL_W-1:0] start_x_reg, start_y_reg;

    setup_t             su_reg;
    logic [TGT_W-1:0]   num_reg;
    logic [DIM_W-1:0]   den_reg, rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIM_W:0]     trial;
    logic               fill;
    logic signed [REL_W-1:0] dx, dy;

    assign cfg_ready = 1'b1;
    assign trial = {rem_reg, num_reg[TGT_W-1]};
    assign fill  = (mode_reg == MODE_FILL);
    assign dx = REL_W'(signed'({1'b0, xres_reg})) - REL_W'(signed'({1'b0, tw_reg}));
    assign dy = REL_W'(signed'({1'b0, yres_reg})) - REL_W'(signed'({1'b0, th_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_cfg_reg <= DIM_W'(1);
            src_h_cfg_reg <= DIM_W'(1);
            scr_w_cfg_reg <= DIM_W'(1);
            scr_h_cfg_reg <= DIM_W'(1);
            stride_reg    <= STRIDE_W'(3);
            rot_reg       <= ROT_0;
            mode_reg      <= MODE_FIT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: src_h_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_ROW_STRIDE:    stride_reg    <= cfg_data;
                REG_SCREEN_WIDTH:  scr_w_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: scr_h_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_ROTATION:      rot_reg       <= cfg_data[1:0];
                REG_SCALE_MODE:    mode_reg      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        w_reg    <= clamp_dim(src_w_cfg_reg);
        h_reg    <= clamp_dim(src_h_cfg_reg);
        xres_reg <= clamp_dim(scr_w_cfg_reg);
        yres_reg <= clamp_dim(scr_h_cfg_reg);
        if (rot_reg == ROT_90 || rot_reg == ROT_270) begin
            rw_reg <= clamp_dim(src_h_cfg_reg);
            rh_reg <= clamp_dim(src_w_cfg_reg);
        end else begin
            rw_reg <= clamp_dim(src_w_cfg_reg);
            rh_reg <= clamp_dim(src_h_cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            su_reg <= SU_LOAD;
        end else if (cfg_valid && cfg_ready) begin
            su_reg <= SU_LOAD;
        end else begin
            unique case (su_reg)
                SU_LOAD: su_reg <= SU_MUL1;
                SU_MUL1: begin
                    if (mode_reg == MODE_ORIG) begin
                        tw_reg <= TGT_W'(rw_reg);
                        th_reg <= TGT_W'(rh_reg);
                        su_reg <= SU_START;
                    end else begin
                        num_reg <= TGT_W'(rh_reg) * TGT_W'(xres_reg);
                        den_reg <= rw_reg;
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(TGT_W - 1);
                        su_reg  <= SU_DIV1;
                    end
                end
                SU_DIV1, SU_DIV2: begin
                    if (trial >= {1'b0, den_reg}) begin
                        rem_reg <= DIM_W'(trial - {1'b0, den_reg});
                        num_reg <= {num_reg[TGT_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[DIM_W-1:0];
                        num_reg <= {num_reg[TGT_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        su_reg <= (su_reg == SU_DIV1) ? SU_CHK : SU_START;
                    end
                end
                SU_CHK: begin
                    if ((!fill && num_reg > TGT_W'(yres_reg)) ||
                        (fill && num_reg < TGT_W'(yres_reg))) begin
                        th_reg  <= TGT_W'(yres_reg);
                        num_reg <= TGT_W'(rw_reg) * TGT_W'(yres_reg);
                        den_reg <= rh_reg;
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(TGT_W - 1);
                        tw_reg  <= '0;
                        su_reg  <= SU_DIV2;
                    end else begin
                        tw_reg <= TGT_W'(xres_reg);
                        th_reg <= at_least_one(num_reg);
                        su_reg <= SU_START;
                    end
                end
                SU_START: begin
                    if (tw_reg == '0) begin
                        tw_reg <= at_least_one(num_reg);
                    end else begin
                        start_x_reg <= dx[REL_W-1] ? -((-dx) >>> 1) : (dx >>> 1);
                        start_y_reg <= dy[REL_W-1] ? -((-dy) >>> 1) : (dy >>> 1);
                        su_reg      <= SU_IDLE;
                    end
                end
                SU_IDLE: su_reg <= SU_IDLE;
                default: su_reg <= SU_LOAD;
            endcase
        end
    end

    logic [NST-1:0] v_reg, en;
    logic [NST-1:0] cov_reg;
    logic signed [REL_W-1:0] relx_reg, rely_reg;
    logic [REM_W-1:0] remx_reg [0:QUO_W];
    logic [REM_W-1:0] remy_reg [0:QUO_W];
    logic [QUO_W-1:0] qx_reg [0:QUO_W-1];
    logic [QUO_W-1:0] qy_reg [0:QUO_W-1];
    logic [COORD_W-1:0] sx_reg, sy_reg, sx3_sx_reg, sx3_sy_reg;
    logic [OFFS_W-1:0]  rowoff_reg;
    logic [STRIDE_W-1:0] coloff_reg;
    logic [DIM_W-1:0] rx13, ry13, sx13, sy13;

    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_ready;
        for (int j = NST - 2; j >= 0; j--) begin
            en[j] = !v_reg[j] || en[j+1];
        end
    end

    assign s_ready = en[0] && (su_reg == SU_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid && s_ready;
            end
            for (int j = 1; j < NST; j++) begin
                if (en[j]) begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            relx_reg   <= REL_W'(signed'({1'b0, s_screen_x})) - start_x_reg;
            rely_reg   <= REL_W'(signed'({1'b0, s_screen_y})) - start_y_reg;
            cov_reg[0] <= ({1'b0, s_screen_x} < xres_reg) && ({1'b0, s_screen_y} < yres_reg);
        end
        if (en[1]) begin
            remx_reg[0] <= REM_W'(relx_reg[TGT_W-1:0]) * REM_W'(rw_reg);
            remy_reg[0] <= REM_W'(rely_reg[TGT_W-1:0]) * REM_W'(rh_reg);
            cov_reg[1]  <= cov_reg[0] && !relx_reg[REL_W-1] && !rely_reg[REL_W-1] &&
                           (relx_reg[TGT_W:0] < {1'b0, tw_reg}) &&
                           (rely_reg[TGT_W:0] < {1'b0, th_reg});
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [REM_W-1:0] dxs, dys;
        logic [QUO_W-1:0] pqx, pqy;
        assign dxs = REM_W'(tw_reg) << SH;
        assign dys = REM_W'(th_reg) << SH;
        if (k == 0) begin : g_first
            assign pqx = '0;
            assign pqy = '0;
        end else begin : g_rest
            assign pqx = qx_reg[k-1];
            assign pqy = qy_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en[k+2]) begin
                cov_reg[k+2] <= cov_reg[k+1];
                if (remx_reg[k] >= dxs) begin
                    remx_reg[k+1] <= remx_reg[k] - dxs;
                    qx_reg[k]     <= {pqx[QUO_W-2:0], 1'b1};
                end else begin
                    remx_reg[k+1] <= remx_reg[k];
                    qx_reg[k]     <= {pqx[QUO_W-2:0], 1'b0};
                end
                if (remy_reg[k] >= dys) begin
                    remy_reg[k+1] <= remy_reg[k] - dys;
                    qy_reg[k]     <= {pqy[QUO_W-2:0], 1'b1};
                end else begin
                    remy_reg[k+1] <= remy_reg[k];
                    qy_reg[k]     <= {pqy[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign rx13 = {1'b0, qx_reg[QUO_W-1]};
    assign ry13 = {1'b0, qy_reg[QUO_W-1]};

    always_comb begin
        unique case (rot_reg)
            ROT_90: begin
                sx13 = ry13;
                sy13 = h_reg - DIM_W'(1) - rx13;
            end
            ROT_180: begin
                sx13 = w_reg - DIM_W'(1) - rx13;
                sy13 = h_reg - DIM_W'(1) - ry13;
            end
            ROT_270: begin
                sx13 = w_reg - DIM_W'(1) - ry13;
                sy13 = rx13;
            end
            default: begin
                sx13 = rx13;
                sy13 = ry13;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[QUO_W+2]) begin
            sx_reg             <= sx13[COORD_W-1:0];
            sy_reg             <= sy13[COORD_W-1:0];
            cov_reg[QUO_W+2]   <= cov_reg[QUO_W+1];
        end
        if (en[QUO_W+3]) begin
            rowoff_reg         <= OFFS_W'(sy_reg) * OFFS_W'(stride_reg);
            coloff_reg         <= STRIDE_W'(sx_reg) * STRIDE_W'(BYTES_PER_PIXEL);
            sx3_sx_reg         <= sx_reg;
            sx3_sy_reg         <= sy_reg;
            cov_reg[QUO_W+3]   <= cov_reg[QUO_W+2];
        end
        if (en[QUO_W+4]) begin
            cov_reg[QUO_W+4]   <= cov_reg[QUO_W+3];
            m_source_x         <= cov_reg[QUO_W+3] ? sx3_sx_reg : '0;
            m_source_y         <= cov_reg[QUO_W+3] ? sx3_sy_reg : '0;
            m_source_offset    <= cov_reg[QUO_W+3] ?
                                  (rowoff_reg + OFFS_W'(coloff_reg)) : '0;
        end
    end

    assign m_valid   = v_reg[NST-1];
    assign m_covered = cov_reg[NST-1];

endmodule

`default_nettype wire

// ===== test/rotate_scale_center_pixel_mapper_tb.sv =====
`default_nettype none

module rotate_scale_center_pixel_mapper_tb;
    import rscpm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               covered;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [OFFS_W-1:0]  offset;
    } pixel_map_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_TYPED} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        int         a;
        int         b;
        pixel_map_t typed;
    } stim_row_t;

    localparam pixel_map_t BLACK = '0;
    localparam int DRAIN_CYCLES = 24;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [COORD_W-1:0]   s_screen_x;
    logic [COORD_W-1:0]   s_screen_y;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_covered;
    logic [COORD_W-1:0]   m_source_x;
    logic [COORD_W-1:0]   m_source_y;
    logic [OFFS_W-1:0]    m_source_offset;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index;
    logic [CDATA_W-1:0]   cfg_data;

    logic [DIM_W-1:0]     img_w, img_h, scr_w, scr_h;
    logic [STRIDE_W-1:0]  stride;
    logic [1:0]           rot, mode;

    pixel_map_t expected_maps[$];
    int errors = 0;
    int results_seen = 0;
    bit burst = 0;

    rotate_scale_center_pixel_mapper i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_screen_x(s_screen_x), .s_screen_y(s_screen_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_covered(m_covered), .m_source_x(m_source_x),
        .m_source_y(m_source_y), .m_source_offset(m_source_offset),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint fix_dim(input longint v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic pixel_map_t map_pixel(input logic [COORD_W-1:0] px,
                                             input logic [COORD_W-1:0] py);
        longint w, h, xres, yres, rw, rh, tw, th, start_x, start_y;
        longint rel_x, rel_y, rx, ry, sx, sy;
        pixel_map_t r;
        r = BLACK;
        w = fix_dim(img_w);
        h = fix_dim(img_h);
        xres = fix_dim(scr_w);
        yres = fix_dim(scr_h);
        rw = (rot == ROT_90 || rot == ROT_270) ? h : w;
        rh = (rot == ROT_90 || rot == ROT_270) ? w : h;
        if (mode == MODE_ORIG) begin
            tw = rw;
            th = rh;
        end else begin
            tw = xres;
            th = rh * tw / rw;
            if ((mode != MODE_FILL && th > yres) || (mode == MODE_FILL && th < yres)) begin
                th = yres;
                tw = rw * th / rh;
            end
        end
        if (tw == 0) tw = 1;
        if (th == 0) th = 1;
        start_x = (xres - tw) / 2;
        start_y = (yres - th) / 2;
        rel_x = longint'(px) - start_x;
        rel_y = longint'(py) - start_y;
        if (px >= xres || py >= yres || rel_x < 0 || rel_x >= tw || rel_y < 0 || rel_y >= th)
            return r;
        rx = rel_x * rw / tw;
        ry = rel_y * rh / th;
        case (rot)
            ROT_90: begin
                sx = ry;
                sy = h - 1 - rx;
            end
            ROT_180: begin
                sx = w - 1 - rx;
                sy = h - 1 - ry;
            end
            ROT_270: begin
                sx = w - 1 - ry;
                sy = rx;
            end
            default: begin
                sx = rx;
                sy = ry;
            end
        endcase
        r.covered = 1'b1;
        r.src_x = sx[COORD_W-1:0];
        r.src_y = sy[COORD_W-1:0];
        r.offset = OFFS_W'(sy * longint'(stride) + sx * 3);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_idle();
        while (expected_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
        cfg_index = idx;
        cfg_data = CDATA_W'(val);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SOURCE_WIDTH:  img_w = DIM_W'(val);
            REG_SOURCE_HEIGHT: img_h = DIM_W'(val);
            REG_ROW_STRIDE:    stride = STRIDE_W'(val);
            REG_SCREEN_WIDTH:  scr_w = DIM_W'(val);
            REG_SCREEN_HEIGHT: scr_h = DIM_W'(val);
            REG_ROTATION:      rot = 2'(val);
            REG_SCALE_MODE:    mode = 2'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(input int x, input int y, input bit typed,
                              input pixel_map_t typed_map);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_screen_x = COORD_W'(x);
        s_screen_y = COORD_W'(y);
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_maps.push_back(typed ? typed_map : map_pixel(s_screen_x, s_screen_y));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic int rand_dim(input bit narrow);
        case ($urandom_range(0, 11))
            0: return 0;
            1: return $urandom_range(4097, 8191);
            2: return 4096;
            3: return 1;
            4: return $urandom_range(1, 4096);
            default: return narrow ? $urandom_range(1, 48) : $urandom_range(1, 300);
        endcase
    endfunction

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (results_seen == 450) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                results_seen++;
            end
            m_ready = burst || ($urandom_range(0, 99) < 75) ||
                      ($urandom_range(0, 99) < 5 ? 1'b0 : 1'b0);
            if (!burst && $urandom_range(0, 99) < 3) begin
                m_ready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pixel_map_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_maps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result covered=%0b x=%0d y=%0d offset=%0d", $time,
                         m_covered, m_source_x, m_source_y, m_source_offset);
            end else begin
                want = expected_maps.pop_front();
                if (want.covered !== m_covered || want.src_x !== m_source_x ||
                    want.src_y !== m_source_y || want.offset !== m_source_offset) begin
                    errors++;
                    $display("%0t: expected covered=%0b x=%0d y=%0d offset=%0d, got %0b %0d %0d %0d",
                             $time, want.covered, want.src_x, want.src_y, want.offset,
                             m_covered, m_source_x, m_source_y, m_source_offset);
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        int xlim, ylim, n;
        s_valid = 0;
        s_screen_x = 0;
        s_screen_y = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 0;
        img_w = 1;
        img_h = 1;
        stride = 3;
        scr_w = 1;
        scr_h = 1;
        rot = ROT_0;
        mode = MODE_FIT;

        rows = '{
            '{ROW_PIX_TYPED, 0, 0, pixel_map_t'{1'b1, 12'd0, 12'd0, 26'd0}},
            '{ROW_PIX_TYPED, 4095, 4095, BLACK},
            '{ROW_PIX_TYPED, 1, 0, BLACK},
            '{ROW_CFG, REG_SOURCE_WIDTH, 4096, BLACK},
            '{ROW_CFG, REG_SOURCE_HEIGHT, 4096, BLACK},
            '{ROW_CFG, REG_ROW_STRIDE, 16383, BLACK},
            '{ROW_CFG, REG_SCREEN_WIDTH, 4096, BLACK},
            '{ROW_CFG, REG_SCREEN_HEIGHT, 4096, BLACK},
            '{ROW_CFG, REG_SCALE_MODE, MODE_ORIG, BLACK},
            '{ROW_PIX_TYPED, 0, 0, pixel_map_t'{1'b1, 12'd0, 12'd0, 26'd0}},
            '{ROW_PIX, 4095, 4095, BLACK},
            '{ROW_CFG, REG_ROTATION, ROT_90, BLACK},
            '{ROW_PIX, 4095, 0, BLACK},
            '{ROW_CFG, REG_ROTATION, ROT_180, BLACK},
            '{ROW_PIX, 2048, 4095, BLACK},
            '{ROW_CFG, REG_ROTATION, ROT_270, BLACK},
            '{ROW_CFG, REG_SOURCE_WIDTH, 8191, BLACK},
            '{ROW_CFG, REG_SOURCE_HEIGHT, 0, BLACK},
            '{ROW_CFG, REG_SCALE_MODE, 3, BLACK},
            '{ROW_PIX, 4095, 2048, BLACK},
            '{ROW_CFG, REG_SCALE_MODE, MODE_FILL, BLACK},
            '{ROW_CFG, REG_ROW_STRIDE, 0, BLACK},
            '{ROW_CFG, 7, 5, BLACK},
            '{ROW_PIX, 1234, 3000, BLACK},
            '{ROW_CFG, REG_SCREEN_WIDTH, 0, BLACK},
            '{ROW_PIX_TYPED, 1, 0, BLACK}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(CIDX_W'(rows[i].a), rows[i].b);
            end else begin
                send_pixel(rows[i].a, rows[i].b, rows[i].kind == ROW_PIX_TYPED, rows[i].typed);
            end
        end

        for (int phase = 0; phase < 12; phase++) begin
            wait_idle();
            write_reg(REG_SOURCE_WIDTH, rand_dim(1'b0));
            write_reg(REG_SOURCE_HEIGHT, rand_dim(1'b0));
            write_reg(REG_ROW_STRIDE, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 16383) : 3 * fix_dim(img_w) + $urandom_range(0, 9));
            write_reg(REG_SCREEN_WIDTH, rand_dim(1'b1));
            write_reg(REG_SCREEN_HEIGHT, rand_dim(1'b1));
            write_reg(REG_ROTATION, $urandom_range(0, 3));
            write_reg(REG_SCALE_MODE, $urandom_range(0, 3));
            xlim = fix_dim(scr_w) - 1;
            ylim = fix_dim(scr_h) - 1;
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 49) == 0) burst = ~burst;
                if ($urandom_range(0, 4) == 0)
                    send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, BLACK);
                else
                    send_pixel($urandom_range(0, xlim), $urandom_range(0, ylim), 1'b0, BLACK);
                n++;
            end
            burst = 0;
        end
        s_valid = 0;

        while (expected_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/rscpm_pkg.sv
design/rotate_scale_center_pixel_mapper.sv
test/rotate_scale_center_pixel_mapper_tb.sv
